// ===== src/slbs_pkg.sv =====
// ----------------------------------------------------------------------------
// slbs_pkg
// Shared types and constants for the smart-LED bit serialiser.
// ----------------------------------------------------------------------------
package slbs_pkg;

    localparam int COLOR_BITS = 24;
    localparam int COUNT_BITS = 8;
    localparam int CFG_WIDTH  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int BIT_IDX_W  = 5;

    // item opcodes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW   = 2'd3;

    // register reset values
    localparam logic [CFG_WIDTH-1:0] ZERO_HIGH_RST = 16'd30;
    localparam logic [CFG_WIDTH-1:0] ZERO_LOW_RST  = 16'd100;
    localparam logic [CFG_WIDTH-1:0] ONE_HIGH_RST  = 16'd100;
    localparam logic [CFG_WIDTH-1:0] ONE_LOW_RST   = 16'd30;

    localparam logic [BIT_IDX_W-1:0] TOP_BIT = 5'd23;

    typedef struct packed {
        logic                  op;
        logic [COUNT_BITS-1:0] led_count;
        logic [COLOR_BITS-1:0] color;
    } in_word_t;

    typedef struct packed {
        logic line;
        logic busy_res;
        logic frame_done;
    } out_word_t;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] zero_high_ticks;
        logic [CFG_WIDTH-1:0] zero_low_ticks;
        logic [CFG_WIDTH-1:0] one_high_ticks;
        logic [CFG_WIDTH-1:0] one_low_ticks;
    } cfg_t;

    typedef struct packed {
        logic active;
        logic in_high_phase;
    } stat_t;

endpackage

// ===== src/smart_led_bit_serializer.sv =====
// ----------------------------------------------------------------------------
// smart_led_bit_serializer
// One-wire smart-LED line driver: start words load a frame, tick words step
// the pulse waveform one tick each and return the line level.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  in       | input     | in_valid / in_ready | in_data  (op, led_count, color)
//  out      | output    | out_valid/out_ready | out_data (line, busy_res, frame_done)
//  cfg      | input     | cfg_we (no wait)    | cfg_index, cfg_data
//
// One word per cycle while out does not stall: each accepted word updates the
// frame state and its result lands in the output register at the same edge.
// in_ready is high whenever the output register is empty or being read.
// Reset clears the frame state and loads the default pulse lengths.
// A stall on out holds the result word and stops intake after one word.
// ----------------------------------------------------------------------------
module smart_led_bit_serializer
    import slbs_pkg::*;
#(
    parameter int TICK_COUNT_WIDTH = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_word_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_word_t            out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0] cfg_data
);

    cfg_t      cfg;
    out_word_t result;
    stat_t     stat;
    logic      take;
    logic      can_load;

    assign in_ready = can_load;
    assign take     = in_valid && can_load;

    slbs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    slbs_core #(
        .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .item   (in_data),
        .cfg    (cfg),
        .result (result),
        .stat   (stat)
    );

    slbs_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take),
        .load_data (result),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // a start on an idle block with LEDs to send opens a frame
    a_start_opens: assert property (@(posedge clk) disable iff (!rst_n)
        (take && in_data.op == OP_START && !stat.active && in_data.led_count != '0)
        |=> (stat.active && stat.in_high_phase && out_data.line && out_data.busy_res))
        else $error("start did not open a frame");

    // the done word closes the frame
    a_done_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (take && result.frame_done) |=> (!stat.active && out_valid && out_data.frame_done))
        else $error("frame still active after done");

    // an empty output register never blocks intake
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("intake blocked with empty output");

    // ticks on an idle block leave it idle and quiet
    a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (take && in_data.op == OP_TICK && !stat.active)
        |=> (!stat.active && !out_data.line && !out_data.busy_res))
        else $error("idle tick changed state");

endmodule

// ===== src/slbs_cfg.sv =====
// ----------------------------------------------------------------------------
// slbs_cfg
// Pulse length registers, written through a plain write port.
// ----------------------------------------------------------------------------
module slbs_cfg
    import slbs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0] cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;

    // register file, one register per index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.zero_high_ticks <= ZERO_HIGH_RST;
            cfg_reg.zero_low_ticks  <= ZERO_LOW_RST;
            cfg_reg.one_high_ticks  <= ONE_HIGH_RST;
            cfg_reg.one_low_ticks   <= ONE_LOW_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ZERO_HIGH: cfg_reg.zero_high_ticks <= cfg_data;
                REG_ZERO_LOW:  cfg_reg.zero_low_ticks  <= cfg_data;
                REG_ONE_HIGH:  cfg_reg.one_high_ticks  <= cfg_data;
                REG_ONE_LOW:   cfg_reg.one_low_ticks   <= cfg_data;
                default:       cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/slbs_core.sv =====
// ----------------------------------------------------------------------------
// slbs_core
// Frame state and pulse timer; works out one result word per accepted word.
// ----------------------------------------------------------------------------
module slbs_core
    import slbs_pkg::*;
#(
    parameter int TICK_COUNT_WIDTH = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      take,
    input  in_word_t  item,
    input  cfg_t      cfg,
    output out_word_t result,
    output stat_t     stat
);

    localparam int CW = (TICK_COUNT_WIDTH > CFG_WIDTH) ? TICK_COUNT_WIDTH : CFG_WIDTH;

    logic                        active_reg,    active_next;
    logic [COLOR_BITS-1:0]       color_reg,     color_next;
    logic [COUNT_BITS-1:0]       leds_reg,      leds_next;
    logic [BIT_IDX_W-1:0]        bit_reg,       bit_next;
    logic                        high_reg,      high_next;
    logic [TICK_COUNT_WIDTH-1:0] phase_reg,     phase_next;

    logic                        cur_bit;
    logic [CFG_WIDTH-1:0]        len_raw;
    logic [CFG_WIDTH-1:0]        len_m1;
    logic [CW-1:0]               len_m1_ext;
    logic [CW-1:0]               mask_ext;
    logic [CW-1:0]               len_sat;
    logic                        phase_end;
    logic [COUNT_BITS-1:0]       leds_dec;

    // pulse length of the current phase, zero read as one, saturated to counter
    always_comb
    begin
        cur_bit = (bit_reg < BIT_IDX_W'(COLOR_BITS)) ? color_reg[bit_reg] : 1'b0;
        if (cur_bit)
            len_raw = high_reg ? cfg.one_high_ticks : cfg.one_low_ticks;
        else
            len_raw = high_reg ? cfg.zero_high_ticks : cfg.zero_low_ticks;
        len_m1     = (len_raw == '0) ? '0 : len_raw - CFG_WIDTH'(1);
        len_m1_ext = CW'(len_m1);
        mask_ext   = CW'({TICK_COUNT_WIDTH{1'b1}});
        len_sat    = (len_m1_ext > mask_ext) ? mask_ext : len_m1_ext;
        phase_end  = (CW'(phase_reg) >= len_sat);
        leds_dec   = leds_reg - COUNT_BITS'(1);
    end

    // next state and result
    always_comb
    begin
        active_next = active_reg;
        color_next  = color_reg;
        leds_next   = leds_reg;
        bit_next    = bit_reg;
        high_next   = high_reg;
        phase_next  = phase_reg;
        result      = '0;

        if (item.op == OP_START)
        begin
            if (!active_reg && (item.led_count != '0))
            begin
                active_next = 1'b1;
                color_next  = item.color;
                leds_next   = item.led_count;
                bit_next    = TOP_BIT;
                high_next   = 1'b1;
                phase_next  = '0;
            end
            result.line     = active_next & high_next;
            result.busy_res = active_next;
        end
        else if (active_reg)
        begin
            result.line     = high_reg;
            result.busy_res = 1'b1;
            if (phase_end)
            begin
                phase_next = '0;
                if (high_reg)
                begin
                    high_next = 1'b0;
                end
                else
                begin
                    high_next = 1'b1;
                    if (bit_reg == '0)
                    begin
                        leds_next = leds_dec;
                        bit_next  = TOP_BIT;
                        if (leds_dec == '0)
                        begin
                            active_next       = 1'b0;
                            high_next         = 1'b0;
                            result.frame_done = 1'b1;
                        end
                    end
                    else
                    begin
                        bit_next = bit_reg - BIT_IDX_W'(1);
                    end
                end
            end
            else
            begin
                phase_next = phase_reg + TICK_COUNT_WIDTH'(1);
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            color_reg  <= '0;
            leds_reg   <= '0;
            bit_reg    <= TOP_BIT;
            high_reg   <= 1'b0;
            phase_reg  <= '0;
        end
        else if (take)
        begin
            active_reg <= active_next;
            color_reg  <= color_next;
            leds_reg   <= leds_next;
            bit_reg    <= bit_next;
            high_reg   <= high_next;
            phase_reg  <= phase_next;
        end
    end

    assign stat.active        = active_reg;
    assign stat.in_high_phase = high_reg;

endmodule

// ===== src/slbs_out_stage.sv =====
// ----------------------------------------------------------------------------
// slbs_out_stage
// Result register with valid/ready; refills in the cycle it is emptied.
// ----------------------------------------------------------------------------
module slbs_out_stage
    import slbs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  out_word_t load_data,
    output logic      can_load,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_data
);

    logic      valid_reg;
    out_word_t data_reg;

    // room when empty or being drained this cycle
    assign can_load = !valid_reg || out_ready;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= load_data;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== test/led_frame_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_frame_checker
// Watches the word channels and the register port of the smart-LED serialiser.
// It keeps its own copy of the frame state and the pulse lengths, works out
// the result word for every accepted input word, and compares each result
// word in order, field by field.
// ----------------------------------------------------------------------------
module led_frame_checker
    import slbs_pkg::*;
#(
    parameter int TICK_COUNT_WIDTH = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  in_word_t             in_data,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  out_word_t            out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0] cfg_data,
    output int                   fail_count
);

    localparam logic [32:0] TICK_MASK = (33'd1 << TICK_COUNT_WIDTH) - 33'd1;

    // mirrored pulse lengths and frame state
    cfg_t                        lengths;
    logic                        frame_on;
    logic [COLOR_BITS-1:0]       colour_reg;
    logic [COUNT_BITS-1:0]       leds_to_go;
    logic [BIT_IDX_W-1:0]        bit_pos;
    logic                        high_phase;
    logic [TICK_COUNT_WIDTH-1:0] spent_ticks;

    // result words still owed by the block, oldest first
    out_word_t line_expected[$];
    out_word_t want;
    out_word_t predicted;
    int        shown;

    initial
    begin
        fail_count = 0;
        shown      = 0;
    end

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (shown < 30)
            $display("[%0t] mismatch: %s", $time, msg);
        shown++;
    endtask

    // length in ticks of the pulse now being sent
    function automatic logic [32:0] pulse_span();
        logic [32:0] span;
        logic        one_bit;
        one_bit = (bit_pos < COLOR_BITS) && colour_reg[bit_pos];
        if (one_bit)
            span = high_phase ? 33'(lengths.one_high_ticks) : 33'(lengths.one_low_ticks);
        else
            span = high_phase ? 33'(lengths.zero_high_ticks) : 33'(lengths.zero_low_ticks);
        if (span == 33'd0)
            span = 33'd1;
        if (span - 33'd1 > TICK_MASK)
            span = TICK_MASK + 33'd1;
        return span;
    endfunction

    // advance the frame by one word and give its result
    task automatic step_frame(input in_word_t w, output out_word_t res);
        logic [32:0] span;
        res = '0;
        if (w.op == OP_START)
        begin
            // a start while busy or with no LEDs leaves the state alone
            if (!frame_on && w.led_count != '0)
            begin
                frame_on    = 1'b1;
                colour_reg  = w.color;
                leds_to_go  = w.led_count;
                bit_pos     = TOP_BIT;
                high_phase  = 1'b1;
                spent_ticks = '0;
            end
            res.line     = frame_on && high_phase;
            res.busy_res = frame_on;
        end
        else if (frame_on)
        begin
            span         = pulse_span();
            res.line     = high_phase;
            res.busy_res = 1'b1;
            if ({{(33-TICK_COUNT_WIDTH){1'b0}}, spent_ticks} + 33'd1 >= span)
            begin
                spent_ticks = '0;
                if (high_phase)
                    high_phase = 1'b0;
                else
                begin
                    high_phase = 1'b1;
                    if (bit_pos == '0)
                    begin
                        // colour word finished for this LED
                        leds_to_go = leds_to_go - 1'b1;
                        bit_pos    = TOP_BIT;
                        if (leds_to_go == '0)
                        begin
                            frame_on       = 1'b0;
                            high_phase     = 1'b0;
                            res.frame_done = 1'b1;
                        end
                    end
                    else
                        bit_pos = bit_pos - 1'b1;
                end
            end
            else
                spent_ticks = spent_ticks + 1'b1;
        end
    endtask

    // anything still owed once the run has drained
    task automatic flush_leftovers();
        while (line_expected.size() > 0)
        begin
            want = line_expected.pop_front();
            report_mismatch("expected result word never arrived");
        end
    endtask

    // compare older results first, then take register writes and new words
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lengths.zero_high_ticks = ZERO_HIGH_RST;
            lengths.zero_low_ticks  = ZERO_LOW_RST;
            lengths.one_high_ticks  = ONE_HIGH_RST;
            lengths.one_low_ticks   = ONE_LOW_RST;
            frame_on    = 1'b0;
            colour_reg  = '0;
            leds_to_go  = '0;
            bit_pos     = TOP_BIT;
            high_phase  = 1'b0;
            spent_ticks = '0;
            line_expected.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (line_expected.size() == 0)
                    report_mismatch("result word with nothing expected");
                else
                begin
                    want = line_expected.pop_front();
                    if (out_data.line !== want.line)
                        report_mismatch($sformatf("line got %b want %b",
                                                  out_data.line, want.line));
                    if (out_data.busy_res !== want.busy_res)
                        report_mismatch($sformatf("busy_res got %b want %b",
                                                  out_data.busy_res, want.busy_res));
                    if (out_data.frame_done !== want.frame_done)
                        report_mismatch($sformatf("frame_done got %b want %b",
                                                  out_data.frame_done, want.frame_done));
                end
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ZERO_HIGH: lengths.zero_high_ticks = cfg_data;
                    REG_ZERO_LOW:  lengths.zero_low_ticks  = cfg_data;
                    REG_ONE_HIGH:  lengths.one_high_ticks  = cfg_data;
                    REG_ONE_LOW:   lengths.one_low_ticks   = cfg_data;
                    default:       ;
                endcase
            end

            if (in_valid && in_ready)
            begin
                step_frame(in_data, predicted);
                line_expected.push_back(predicted);
            end
        end
    end

endmodule

// ===== test/smart_led_bit_serializer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smart_led_bit_serializer_tb
// Drives start and tick words into the smart-LED serialiser under changing
// pulse lengths and stall patterns; every frame runs until the line goes idle.
// The checker beside the block predicts and compares each result word.
// ----------------------------------------------------------------------------
module smart_led_bit_serializer_tb;
    import slbs_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    in_word_t             in_data;
    logic                 out_valid;
    logic                 out_ready;
    out_word_t            out_data;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_WIDTH-1:0] cfg_data;
    int                   fail_count;

    // stall odds in percent for each side
    int send_idle;
    int recv_idle;

    // bookkeeping of accepted words
    int n_in;
    int n_out;
    int last_idle_idx;
    int frames_seen;
    int frame_starts;
    int settings_made;

    smart_led_bit_serializer DUT (.*);

    led_frame_checker frame_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #30_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    // track result words: index of the latest idle one and finished frames
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (!out_data.busy_res)
                last_idle_idx <= n_out;
            if (out_data.frame_done)
                frames_seen <= frames_seen + 1;
            n_out <= n_out + 1;
        end
    end

    function automatic in_word_t word_of(input logic op,
                                         input logic [COUNT_BITS-1:0] count,
                                         input logic [COLOR_BITS-1:0] colour);
        in_word_t w;
        w.op        = op;
        w.led_count = count;
        w.color     = colour;
        return w;
    endfunction

    function automatic in_word_t random_tick();
        return word_of(OP_TICK, COUNT_BITS'($urandom_range(0, 255)),
                       COLOR_BITS'($urandom_range(0, 24'hFFFFFF)));
    endfunction

    // mostly very short pulses, now and then longer ones
    function automatic logic [CFG_WIDTH-1:0] short_len();
        if ($urandom_range(0, 99) < 85)
            return CFG_WIDTH'($urandom_range(0, 2));
        return CFG_WIDTH'($urandom_range(3, 6));
    endfunction

    // offer one word and hold it until taken
    task automatic push_word(input in_word_t w);
        while ($urandom_range(0, 99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        n_in++;
    endtask

    // stop sending and let every owed result word come back
    task automatic settle();
        in_valid <= 1'b0;
        while (n_out != n_in)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // rewrite all four pulse lengths while the block is quiet
    task automatic set_lengths(input logic [CFG_WIDTH-1:0] zh, input logic [CFG_WIDTH-1:0] zl,
                               input logic [CFG_WIDTH-1:0] oh, input logic [CFG_WIDTH-1:0] ol);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_ZERO_HIGH;
        cfg_data  <= zh;
        @(posedge clk);
        cfg_index <= REG_ZERO_LOW;
        cfg_data  <= zl;
        @(posedge clk);
        cfg_index <= REG_ONE_HIGH;
        cfg_data  <= oh;
        @(posedge clk);
        cfg_index <= REG_ONE_LOW;
        cfg_data  <= ol;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        settings_made++;
    endtask

    // start a frame and tick it until a later result word shows the line idle;
    // cut_in is an extra start pushed after cut_in_at ticks, while still busy
    task automatic run_frame(input logic [COUNT_BITS-1:0] count,
                             input logic [COLOR_BITS-1:0] colour,
                             input int cut_in_at, input in_word_t cut_in);
        int start_idx;
        int ticks;
        start_idx = n_in;
        push_word(word_of(OP_START, count, colour));
        frame_starts++;
        ticks = 0;
        while (last_idle_idx <= start_idx)
        begin
            if (ticks == cut_in_at)
                push_word(cut_in);
            push_word(random_tick());
            ticks++;
        end
    endtask

    // one well-formed frame with random content, then some idle noise
    task automatic random_frame();
        logic [COUNT_BITS-1:0] count;
        logic [COLOR_BITS-1:0] colour;
        int                    pick;
        int                    cut_at;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            count = '0;
        else if (pick < 85)
            count = COUNT_BITS'($urandom_range(1, 2));
        else
            count = COUNT_BITS'($urandom_range(3, 4));
        pick = $urandom_range(0, 99);
        if (pick < 10)
            colour = '0;
        else if (pick < 20)
            colour = '1;
        else
            colour = COLOR_BITS'($urandom_range(0, 24'hFFFFFF));
        cut_at = (count != '0 && $urandom_range(0, 1) == 1) ? $urandom_range(0, 6) : -1;
        run_frame(count, colour, cut_at,
                  word_of(OP_START, COUNT_BITS'($urandom_range(0, 255)),
                          COLOR_BITS'($urandom_range(0, 24'hFFFFFF))));
        repeat ($urandom_range(0, 3))
            push_word(random_tick());
        if ($urandom_range(0, 5) == 0)
            push_word(word_of(OP_START, '0, COLOR_BITS'($urandom_range(0, 24'hFFFFFF))));
    endtask

    task automatic random_phase(input int words);
        int stop_at;
        stop_at = n_in + words;
        while (n_in < stop_at)
        begin
            if ($urandom_range(0, 2) == 0)
                set_lengths(short_len(), short_len(), short_len(), short_len());
            random_frame();
        end
    endtask

    initial
    begin
        in_valid      <= 1'b0;
        in_data       <= '0;
        cfg_we        <= 1'b0;
        cfg_index     <= REG_ZERO_HIGH;
        cfg_data      <= '0;
        rst_n         <= 1'b0;
        n_in          = 0;
        n_out         = 0;
        last_idle_idx = -1;
        frames_seen   = 0;
        frame_starts  = 0;
        settings_made = 0;
        send_idle     = 18;
        recv_idle     = 85;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: idle tick, empty start, the first bit at reset lengths
        push_word(word_of(OP_TICK, '1, '1));
        push_word(word_of(OP_START, '0, '1));
        push_word(word_of(OP_START, 8'd1, 24'hA5C30F));
        frame_starts++;
        repeat (135)
            push_word(random_tick());

        // shorter lengths taken mid-frame; this start is ignored while busy
        set_lengths(16'd1, 16'd2, 16'd2, 16'd1);
        run_frame(8'd1, 24'h000000, -1, '0);

        // plain colours and starts arriving mid-frame
        run_frame(8'd1, 24'hFFFFFF, 0, word_of(OP_START, 8'hFF, 24'hFFFFFF));
        run_frame(8'd1, 24'h5A5A5A, 3, word_of(OP_START, 8'h00, 24'h000000));
        random_phase(60);

        // sender slow, receiver mostly ready
        send_idle = 85;
        recv_idle = 18;
        set_lengths(short_len(), short_len(), short_len(), short_len());
        random_phase(60);

        // no stalls: longer pulses, zero lengths, a two-LED frame
        send_idle = 0;
        recv_idle = 0;
        set_lengths(16'd0, 16'd0, 16'd12, 16'd0);
        run_frame(8'd1, 24'h000001, -1, '0);
        set_lengths(16'd12, 16'd12, 16'd1, 16'd1);
        run_frame(8'd1, 24'hFFFFFE, -1, '0);
        set_lengths(16'd0, 16'd0, 16'd0, 16'd0);
        run_frame(8'd2, 24'h3C96E1, 5, word_of(OP_START, 8'd1, 24'h123456));
        random_phase(60);

        settle();
        frame_check.flush_leftovers();
        @(posedge clk);
        $display("Run covered %0d words in %0d frame starts, %0d frames finished,",
                 n_in, frame_starts, frames_seen);
        $display("under %0d pulse-length settings and three stall mixes.", settings_made);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
